// ----- hdl/tspq_pkg.sv -----
package tspq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_WIDTH    = 8;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // event types and priority registers
    localparam int TYPE_W    = 3;
    localparam int PRIO_W    = 8;
    localparam int NUM_PRIO  = 6;
    localparam int CFG_IDX_W = 3;

    // action codes
    localparam logic ACT_ADD = 1'b0;
    localparam logic ACT_POP = 1'b1;

    typedef logic [NUM_PRIO-1:0][PRIO_W-1:0] t_prio_arr;

    // reset priorities: none, dialogue, skill, passive, revive, death
    localparam t_prio_arr PRIO_RESET = {8'd2, 8'd3, 8'd25, 8'd20, 8'd1, 8'd0};

    // one stored entry; priority latched at insertion
    typedef struct packed {
        logic [PRIO_W-1:0]   prio;
        logic [TYPE_W-1:0]   etype;
        logic [ID_WIDTH-1:0] id;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

// ----- hdl/tspq_ram.sv -----
module tspq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- hdl/typed_stable_priority_queue.sv -----
// Add: result in the cycle after the item is accepted; one item per cycle while adds flow.
// Pop: one RAM read per cycle to scan the held entries for the lowest priority, then one
//   read and one write per cycle to close the gap behind the winner. Empty pop: result in
//   the cycle after acceptance. A stalled result holds the input off until it is taken.
// Reset (synchronous, active low) empties the queue and restores the priority registers;
//   the entry RAM is not cleared, slots at or above the fill count are never read.
module typed_stable_priority_queue (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration
    input  logic                           i_cfg_we,
    input  logic [tspq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tspq_pkg::PRIO_W-1:0]    i_cfg_data,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic                           i_action,
    input  logic [tspq_pkg::ID_WIDTH-1:0]  i_entry_id,
    input  logic [tspq_pkg::TYPE_W-1:0]    i_entry_type,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_popped_valid,
    output logic [tspq_pkg::ID_WIDTH-1:0]  o_popped_id,
    output logic [tspq_pkg::TYPE_W-1:0]    o_popped_type,
    output logic                           o_queue_done,
    output logic                           o_add_dropped,
    output logic [tspq_pkg::CNT_W-1:0]     o_fill_count
);

    localparam int IW = tspq_pkg::IDX_W;
    localparam int CW = tspq_pkg::CNT_W;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SHIFT, S_FIN} t_state;

    t_state                        r_state, n_state;
    logic [CW-1:0]                 r_held, n_held;
    logic [CW-1:0]                 r_rd_idx, n_rd_idx;
    logic                          r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]                 r_cmp_idx, n_cmp_idx;
    logic [IW-1:0]                 r_best_idx, n_best_idx;
    tspq_pkg::t_entry              r_best, n_best;

    logic                          r_out_valid, n_out_valid;
    logic                          r_popped_valid, n_popped_valid;
    logic [tspq_pkg::ID_WIDTH-1:0] r_popped_id, n_popped_id;
    logic [tspq_pkg::TYPE_W-1:0]   r_popped_type, n_popped_type;
    logic                          r_queue_done, n_queue_done;
    logic                          r_add_dropped, n_add_dropped;
    logic [CW-1:0]                 r_fill, n_fill;

    tspq_pkg::t_prio_arr           r_prio;

    logic                          ram_we;
    logic [IW-1:0]                 ram_waddr;
    tspq_pkg::t_entry              ram_wdata;
    logic [IW-1:0]                 ram_raddr;
    tspq_pkg::t_entry              ram_rdata;

    logic                          out_free;
    logic                          in_fire;
    logic                          last_cmp;
    logic [tspq_pkg::PRIO_W-1:0]   add_prio;

    function automatic logic [tspq_pkg::CFG_IDX_W-1:0] CFG_LIMIT();
        return tspq_pkg::CFG_IDX_W'(tspq_pkg::NUM_PRIO);
    endfunction

    // priority registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio <= tspq_pkg::PRIO_RESET;
        end else if (i_cfg_we && (i_cfg_idx < CFG_LIMIT())) begin
            r_prio[i_cfg_idx] <= i_cfg_data;
        end
    end

    // priority of the incoming type; unknown codes take the none priority
    assign add_prio = (i_entry_type < tspq_pkg::TYPE_W'(tspq_pkg::NUM_PRIO))
                      ? r_prio[i_entry_type] : r_prio[0];

    // entry store
    tspq_ram #(
        .WIDTH (tspq_pkg::ENTRY_W),
        .DEPTH (tspq_pkg::QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshakes
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_fire    = i_in_valid && o_in_ready;
    assign last_cmp   = r_cmp_vld && (CW'(r_cmp_idx) == (r_held - CW'(1)));

    // next-state logic
    always_comb begin
        n_state        = r_state;
        n_held         = r_held;
        n_rd_idx       = r_rd_idx;
        n_cmp_vld      = r_cmp_vld;
        n_cmp_idx      = r_cmp_idx;
        n_best_idx     = r_best_idx;
        n_best         = r_best;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_popped_valid = r_popped_valid;
        n_popped_id    = r_popped_id;
        n_popped_type  = r_popped_type;
        n_queue_done   = r_queue_done;
        n_add_dropped  = r_add_dropped;
        n_fill         = r_fill;
        ram_we         = 1'b0;
        ram_waddr      = r_held[IW-1:0];
        ram_wdata      = '{prio: add_prio, etype: i_entry_type, id: i_entry_id};
        ram_raddr      = '0;

        unique case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_action == tspq_pkg::ACT_ADD) begin
                        n_out_valid    = 1'b1;
                        n_popped_valid = 1'b0;
                        n_popped_id    = '0;
                        n_popped_type  = '0;
                        n_queue_done   = 1'b0;
                        if (r_held == CW'(tspq_pkg::QUEUE_DEPTH)) begin
                            n_add_dropped = 1'b1;
                            n_fill        = r_held;
                        end else begin
                            ram_we        = 1'b1;
                            n_held        = r_held + CW'(1);
                            n_add_dropped = 1'b0;
                            n_fill        = r_held + CW'(1);
                        end
                    end else if (r_held == '0) begin
                        // empty pop ends the turn
                        n_out_valid    = 1'b1;
                        n_popped_valid = 1'b0;
                        n_popped_id    = '0;
                        n_popped_type  = '0;
                        n_queue_done   = 1'b1;
                        n_add_dropped  = 1'b0;
                        n_fill         = '0;
                    end else begin
                        ram_raddr = '0;
                        n_rd_idx  = CW'(1);
                        n_cmp_vld = 1'b1;
                        n_cmp_idx = '0;
                        n_state   = S_SCAN;
                    end
                end
            end

            S_SCAN: begin
                // strict less keeps the earliest entry among equals
                if (r_cmp_vld && ((r_cmp_idx == '0) || (ram_rdata.prio < r_best.prio))) begin
                    n_best_idx = r_cmp_idx;
                    n_best     = ram_rdata;
                end
                if (last_cmp) begin
                    n_cmp_vld = 1'b0;
                    if ((CW'(n_best_idx) + CW'(1)) < r_held) begin
                        n_rd_idx = CW'(n_best_idx) + CW'(1);
                        n_state  = S_SHIFT;
                    end else begin
                        n_state = S_FIN;
                    end
                end else if (r_rd_idx < r_held) begin
                    ram_raddr = r_rd_idx[IW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[IW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end

            S_SHIFT: begin
                // move each later entry down by one slot
                if (r_cmp_vld) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_cmp_idx - IW'(1);
                    ram_wdata = ram_rdata;
                end
                if (last_cmp) begin
                    n_cmp_vld = 1'b0;
                    n_state   = S_FIN;
                end else if (r_rd_idx < r_held) begin
                    ram_raddr = r_rd_idx[IW-1:0];
                    n_rd_idx  = r_rd_idx + CW'(1);
                    n_cmp_vld = 1'b1;
                    n_cmp_idx = r_rd_idx[IW-1:0];
                end else begin
                    n_cmp_vld = 1'b0;
                end
            end

            S_FIN: begin
                if (out_free) begin
                    n_out_valid    = 1'b1;
                    n_popped_valid = 1'b1;
                    n_popped_id    = r_best.id;
                    n_popped_type  = r_best.etype;
                    n_queue_done   = 1'b0;
                    n_add_dropped  = 1'b0;
                    n_held         = r_held - CW'(1);
                    n_fill         = r_held - CW'(1);
                    n_state        = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_held      <= '0;
            r_cmp_vld   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_held      <= n_held;
            r_cmp_vld   <= n_cmp_vld;
            r_out_valid <= n_out_valid;
        end
        r_rd_idx       <= n_rd_idx;
        r_cmp_idx      <= n_cmp_idx;
        r_best_idx     <= n_best_idx;
        r_best         <= n_best;
        r_popped_valid <= n_popped_valid;
        r_popped_id    <= n_popped_id;
        r_popped_type  <= n_popped_type;
        r_queue_done   <= n_queue_done;
        r_add_dropped  <= n_add_dropped;
        r_fill         <= n_fill;
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_valid = r_popped_valid;
    assign o_popped_id    = r_popped_id;
    assign o_popped_type  = r_popped_type;
    assign o_queue_done   = r_queue_done;
    assign o_add_dropped  = r_add_dropped;
    assign o_fill_count   = r_fill;

endmodule

// ----- hdl/tspq_checker.sv -----
module tspq_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_cfg_we,
    input logic [tspq_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input logic [tspq_pkg::PRIO_W-1:0]    i_cfg_data,
    input logic                           i_in_valid,
    input logic                           o_in_ready,
    input logic                           i_action,
    input logic [tspq_pkg::ID_WIDTH-1:0]  i_entry_id,
    input logic [tspq_pkg::TYPE_W-1:0]    i_entry_type,
    input logic                           o_out_valid,
    input logic                           i_out_ready,
    input logic                           o_popped_valid,
    input logic [tspq_pkg::ID_WIDTH-1:0]  o_popped_id,
    input logic [tspq_pkg::TYPE_W-1:0]    o_popped_type,
    input logic                           o_queue_done,
    input logic                           o_add_dropped,
    input logic [tspq_pkg::CNT_W-1:0]     o_fill_count
);

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_popped_id)
            && $stable(o_popped_type) && $stable(o_fill_count))
        else $error("result changed while stalled");

    // an empty pop leaves nothing held and returns no entry
    a_done_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_queue_done |-> (o_fill_count == '0) && !o_popped_valid
            && (o_popped_id == '0) && !o_add_dropped)
        else $error("empty pop reported with entry or fill");

    // a dropped add only when full
    a_drop_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_add_dropped |->
            o_fill_count == tspq_pkg::CNT_W'(tspq_pkg::QUEUE_DEPTH))
        else $error("add dropped below full");

    // nothing is presented right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind typed_stable_priority_queue tspq_checker u_tspq_checker (.*);

// ----- sim/event_queue_check_pkg.sv -----
package event_queue_check_pkg;

    import tspq_pkg::*;

    // one result item as the block reports it
    typedef struct packed {
        logic                popped_valid;
        logic [ID_WIDTH-1:0] popped_id;
        logic [TYPE_W-1:0]   popped_type;
        logic                queue_done;
        logic                add_dropped;
        logic [CNT_W-1:0]    fill_count;
    } outcome_t;

    localparam int MAX_REPORTS = 10;

    class event_queue_scoreboard;

        logic [PRIO_W-1:0] prio_regs [NUM_PRIO];
        t_entry            held_entries [$];   // insertion order, prio latched on add
        outcome_t          due_outcomes [$];   // predicted results, oldest first
        int                n_errors;
        int                n_checked;
        int                n_adds;
        int                n_pops;
        int                n_dropped;
        int                n_empty_pops;
        int                peak_fill;

        function new();
            foreach (prio_regs[i]) prio_regs[i] = PRIO_RESET[i];
            n_errors     = 0;
            n_checked    = 0;
            n_adds       = 0;
            n_pops       = 0;
            n_dropped    = 0;
            n_empty_pops = 0;
            peak_fill    = 0;
        endfunction

        // register writes beyond the last priority slot are ignored
        function void set_priority(int idx, logic [PRIO_W-1:0] val);
            if (idx >= 0 && idx < NUM_PRIO) prio_regs[idx] = val;
        endfunction

        function int outstanding();
            return due_outcomes.size();
        endfunction

        // accepted input item: update the queue copy and predict its result
        function void note_item(logic action, logic [ID_WIDTH-1:0] id,
                                logic [TYPE_W-1:0] etype);
            outcome_t want;
            t_entry   ent;
            int       best;
            int       i;
            want = '0;
            if (action == ACT_ADD) begin
                n_adds++;
                if (held_entries.size() >= QUEUE_DEPTH) begin
                    want.add_dropped = 1'b1;
                    n_dropped++;
                end else begin
                    ent.id    = id;
                    ent.etype = etype;
                    // undefined type codes fall back to the "none" priority
                    if (etype < NUM_PRIO) ent.prio = prio_regs[etype];
                    else ent.prio = prio_regs[0];
                    held_entries.push_back(ent);
                end
            end else begin
                n_pops++;
                if (held_entries.size() == 0) begin
                    want.queue_done = 1'b1;
                    n_empty_pops++;
                end else begin
                    // strict less-than keeps the earliest of equal priorities
                    best = 0;
                    for (i = 1; i < held_entries.size(); i++) begin
                        if (held_entries[i].prio < held_entries[best].prio) best = i;
                    end
                    want.popped_valid = 1'b1;
                    want.popped_id    = held_entries[best].id;
                    want.popped_type  = held_entries[best].etype;
                    held_entries.delete(best);
                end
            end
            want.fill_count = CNT_W'(held_entries.size());
            if (held_entries.size() > peak_fill) peak_fill = held_entries.size();
            due_outcomes.push_back(want);
        endfunction

        // accepted result item: compare with the oldest prediction
        function void check_item(outcome_t got);
            outcome_t want;
            logic     bad;
            n_checked++;
            if (due_outcomes.size() == 0) begin
                if (n_errors < MAX_REPORTS)
                    $display("ERROR: result %0d arrived with nothing expected", n_checked);
                n_errors++;
                return;
            end
            want = due_outcomes.pop_front();
            bad = (got.popped_valid !== want.popped_valid) ||
                  (got.popped_id    !== want.popped_id)    ||
                  (got.popped_type  !== want.popped_type)  ||
                  (got.queue_done   !== want.queue_done)   ||
                  (got.add_dropped  !== want.add_dropped)  ||
                  (got.fill_count   !== want.fill_count);
            if (bad) begin
                if (n_errors < MAX_REPORTS) begin
                    $display("ERROR: result %0d expected %s", n_checked,
                             $sformatf("vld=%0b id=%0d type=%0d done=%0b drop=%0b fill=%0d",
                                       want.popped_valid, want.popped_id,
                                       want.popped_type, want.queue_done,
                                       want.add_dropped, want.fill_count));
                    $display("       got             %s",
                             $sformatf("vld=%0b id=%0d type=%0d done=%0b drop=%0b fill=%0d",
                                       got.popped_valid, got.popped_id,
                                       got.popped_type, got.queue_done,
                                       got.add_dropped, got.fill_count));
                end
                n_errors++;
            end
        endfunction

    endclass

endpackage

// ----- sim/tb.sv -----
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tspq_pkg::*;
    import event_queue_check_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_WAIT  = 2 * QUEUE_DEPTH + 8;
    localparam int RESET_CYCLES = 9;

    // priority settings used across the phases
    typedef enum int {
        PRIO_ALL_ZERO,
        PRIO_ALL_MAX,
        PRIO_EXTREMES,
        PRIO_NARROW,
        PRIO_ANY
    } prio_mode_t;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx    = '0;
    logic [PRIO_W-1:0]    i_cfg_data   = '0;
    logic                 i_in_valid   = 1'b0;
    logic                 i_action     = 1'b0;
    logic [ID_WIDTH-1:0]  i_entry_id   = '0;
    logic [TYPE_W-1:0]    i_entry_type = '0;
    logic                 i_out_ready  = 1'b0;

    logic                 o_in_ready;
    logic                 o_out_valid;
    logic                 o_popped_valid;
    logic [ID_WIDTH-1:0]  o_popped_id;
    logic [TYPE_W-1:0]    o_popped_type;
    logic                 o_queue_done;
    logic                 o_add_dropped;
    logic [CNT_W-1:0]     o_fill_count;

    event_queue_scoreboard sb;
    outcome_t              observed;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_req      = 0;
    int unsigned hold_seen     = 0;
    int unsigned hold_left     = 0;
    int unsigned cycle_count   = 0;

    typed_stable_priority_queue DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_entry_id     (i_entry_id),
        .i_entry_type   (i_entry_type),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_valid (o_popped_valid),
        .o_popped_id    (o_popped_id),
        .o_popped_type  (o_popped_type),
        .o_queue_done   (o_queue_done),
        .o_add_dropped  (o_add_dropped),
        .o_fill_count   (o_fill_count)
    );

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: check accepted items, then choose next ready
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            observed.popped_valid = o_popped_valid;
            observed.popped_id    = o_popped_id;
            observed.popped_type  = o_popped_type;
            observed.queue_done   = o_queue_done;
            observed.add_dropped  = o_add_dropped;
            observed.fill_count   = o_fill_count;
            sb.check_item(observed);
        end
        // long hold-off on request, so the block backs up into its input
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // offer one item, valid held until accepted; valid only drops on an idle gap
    task automatic send_item(input logic act, input logic [ID_WIDTH-1:0] id,
                             input logic [TYPE_W-1:0] etype);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_action     <= act;
        i_entry_id   <= id;
        i_entry_type <= etype;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_item(act, id, etype);
    endtask

    // stop offering and wait for every predicted result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input int idx, input logic [PRIO_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_IDX_W'(idx);
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_priority(idx, val);
        @(posedge i_clk);
    endtask

    task automatic load_priorities(input prio_mode_t mode);
        int                r;
        logic [PRIO_W-1:0] val;
        for (r = 0; r < NUM_PRIO; r++) begin
            case (mode)
                PRIO_ALL_ZERO: val = '0;
                PRIO_ALL_MAX:  val = '1;
                PRIO_EXTREMES: val = $urandom_range(1) ? '1 : '0;
                PRIO_NARROW:   val = PRIO_W'($urandom_range(3));
                default:       val = PRIO_W'($urandom);
            endcase
            write_reg(r, val);
        end
    endtask

    // mixed adds and pops; the add share shifts every 40 items to hit full and empty
    task automatic run_random(input int n_items);
        int                  k;
        int unsigned         add_pct;
        logic [ID_WIDTH-1:0] id;
        logic [TYPE_W-1:0]   etype;
        add_pct = 50;
        for (k = 0; k < n_items; k++) begin
            if (k % 40 == 0) begin
                case ($urandom_range(2))
                    0:       add_pct = 25;
                    1:       add_pct = 50;
                    default: add_pct = 80;
                endcase
            end
            id = ID_WIDTH'($urandom);
            if ($urandom_range(9) == 0) etype = TYPE_W'($urandom_range(7, 6));
            else etype = TYPE_W'($urandom_range(5));
            send_item(($urandom_range(99) < add_pct) ? ACT_ADD : ACT_POP, id, etype);
        end
    endtask

    // directed opening: empty pop, every type code, ties, fill and overflow
    task automatic run_directed();
        int t;
        send_item(ACT_POP, '1, 3'd7);
        for (t = 0; t < 8; t++)
            send_item(ACT_ADD, t[0] ? ID_WIDTH'(255 - t) : ID_WIDTH'(t), TYPE_W'(t));
        send_item(ACT_POP, '0, '0);
        send_item(ACT_POP, '1, '1);
        for (t = 0; t < 10; t++)
            send_item(ACT_ADD, ID_WIDTH'(16 * t + 5), TYPE_W'(t % 6));
        send_item(ACT_ADD, 8'hA5, 3'd2);
        send_item(ACT_POP, '0, '0);
    endtask

    initial begin
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sender idles lightly, receiver heavily
        send_idle_pct = 16;
        recv_idle_pct <= 52;
        run_directed();
        wait_drained();
        run_random(110);
        wait_drained();

        // entries still held keep their priorities across these writes
        load_priorities(PRIO_ALL_ZERO);
        write_reg(6, PRIO_W'($urandom));
        write_reg(7, PRIO_W'($urandom));
        hold_req <= hold_req + 1;
        run_random(110);
        wait_drained();

        // roles swapped
        send_idle_pct = 52;
        recv_idle_pct <= 16;
        load_priorities(PRIO_ALL_MAX);
        run_random(110);
        wait_drained();
        load_priorities(PRIO_EXTREMES);
        run_random(110);
        wait_drained();

        // no idling at all
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        load_priorities(PRIO_NARROW);
        hold_req <= hold_req + 1;
        run_random(120);
        wait_drained();
        load_priorities(PRIO_ANY);
        run_random(120);
        wait_drained();

        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Covered %0d adds and %0d pops over six priority settings, two long stalls",
                 sb.n_adds, sb.n_pops);
        $display("%0d adds refused when full, %0d pops on an empty queue, peak fill %0d",
                 sb.n_dropped, sb.n_empty_pops, sb.peak_fill);
        if (sb.n_errors == 0 && sb.outstanding() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.n_errors, sb.outstanding());
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
